[sv/sliding_window_transport_control_assert.svh]
// Assertion macros for the sliding-window transport controller.
// Included by the top level; needs nothing else.
`ifndef SLIDING_WINDOW_TRANSPORT_CONTROL_ASSERT_SVH
`define SLIDING_WINDOW_TRANSPORT_CONTROL_ASSERT_SVH

// Same-cycle implication under synchronous reset
`define SWTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset
`define SWTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/swtc_pkg.sv]
// Shared types and constants of the sliding-window transport controller.
// Used by the controller, the datapath and the top level; no dependencies.
package swtc_pkg;

  // Field widths fixed by the request format
  localparam int FUNC_W      = 2;
  localparam int KIND_W      = 3;
  localparam int PEER_W      = 16;
  localparam int FIELD_W     = 11;
  localparam int WINDOW_W    = 11;
  localparam int TIMER_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Register reset values
  localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 11'd16;
  localparam logic [TIMER_W-1:0]  TIMEOUT_RESET = 16'd1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_QUEUE = 2'd0,
    FUNC_RECV  = 2'd1,
    FUNC_POLL  = 2'd2,
    FUNC_TICK  = 2'd3
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUEUED    = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_DELIVERED = 3'd2,
    KIND_INVALID   = 3'd3,
    KIND_SEND      = 3'd4,
    KIND_PURE_ACK  = 3'd5,
    KIND_RETX      = 3'd6
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // take the input request
    logic clear_step;  // clear one map entry
    logic exec;        // main update for the latched request
    logic scan_rd;     // read map at delivered count
    logic scan_adv;    // deliver one packet
    logic rx_finish;   // close a receive, build its result
    logic emit;        // push next result slot to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  clear_last;
    func_t func;
    logic  rx_invalid;
    logic  scan_more;
    logic  map_bit;
    logic  slot_any;
    logic  slot_two;
    logic  out_free;
  } status_t;

endpackage

[sv/swtc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swtc_ram #(
  parameter int WIDTH  = 1,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/swtc_ctrl.sv]
// Sequencing state machine of the sliding-window transport controller.
// Depends on swtc_pkg for the command and status structs.
module swtc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  swtc_pkg::status_t  status,
  output swtc_pkg::cmd_t     cmd
);

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_EXEC     = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CHK = 6'b010000,
    ST_EMIT     = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (status.func)
          swtc_pkg::FUNC_QUEUE: state_nxt = ST_EMIT;
          swtc_pkg::FUNC_RECV:  state_nxt = status.rx_invalid ? ST_EMIT : ST_SCAN_RD;
          swtc_pkg::FUNC_POLL:  state_nxt = ST_EMIT;
          swtc_pkg::FUNC_TICK:  state_nxt = ST_IDLE;
          default:              state_nxt = ST_IDLE;
        endcase
      end
      ST_SCAN_RD: begin
        if (status.scan_more) begin
          cmd.scan_rd = 1'b1;
          state_nxt   = ST_SCAN_CHK;
        end else begin
          cmd.rx_finish = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_SCAN_CHK: begin
        if (status.map_bit) begin
          cmd.scan_adv = 1'b1;
          state_nxt    = ST_SCAN_RD;
        end else begin
          cmd.rx_finish = 1'b1;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // one result per cycle into the output register while it is free
        if (!status.slot_any) begin
          state_nxt = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (!status.slot_two) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/swtc_dp.sv]
// Datapath of the sliding-window transport controller: sequence counters,
// timer, received map RAM, result slots and output register.
// Depends on swtc_pkg and swtc_ram.
module swtc_dp #(
  parameter int SEQ_SPACE = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swtc_pkg::cmd_t                      cmd,
  output swtc_pkg::status_t                   status,
  input  logic [swtc_pkg::FUNC_W-1:0]         in_tuser,
  input  logic [swtc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swtc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [swtc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [swtc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [swtc_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast
);

  localparam int CW = $clog2(SEQ_SPACE + 1);
  localparam int AW = $clog2(SEQ_SPACE);
  localparam int SW = ((CW > swtc_pkg::WINDOW_W) ? CW : swtc_pkg::WINDOW_W) + 1;
  localparam int XW = ((CW > swtc_pkg::PEER_W) ? CW : swtc_pkg::PEER_W) + 1;
  localparam int FW = swtc_pkg::FIELD_W;
  localparam int PW = swtc_pkg::PEER_W;
  localparam logic [CW-1:0] LAST_Q  = CW'(SEQ_SPACE - 1);
  localparam logic [CW-1:0] SPACE_C = CW'(SEQ_SPACE);
  localparam logic [AW-1:0] LAST_A  = AW'(SEQ_SPACE - 1);

  // Latched request
  swtc_pkg::func_t   func_r;
  logic [PW-1:0]     pseq_r;
  logic [PW-1:0]     pack_r;

  // Registers and endpoint state
  logic [swtc_pkg::WINDOW_W-1:0] ws_r;
  logic [swtc_pkg::TIMER_W-1:0]  to_r;
  logic [swtc_pkg::TIMER_W-1:0]  elapsed_r;
  logic [CW-1:0]                 delivered_r;
  logic [CW-1:0]                 queued_r;
  logic [CW-1:0]                 nts_r;
  logic [CW-1:0]                 base_r;
  logic                          ackp_r;
  logic [AW-1:0]                 clr_r;

  // Receive scan
  logic [CW-1:0] first_r;
  logic [CW-1:0] run_r;

  // Result slots
  logic              slot0_v_r, slot1_v_r;
  swtc_pkg::kind_t   slot0_kind_r, slot1_kind_r;
  logic [CW-1:0]     slot0_seq_r, slot1_seq_r;

  // Output register
  logic              out_valid_r;
  swtc_pkg::kind_t   out_kind_r;
  logic [FW-1:0]     out_seq_r, out_ack_r, out_run_r;
  logic              out_last_r;

  // Map RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [0:0]    ram_wdata;
  logic [0:0]    ram_rdata;

  // Decisions on current state
  logic          q_room, rx_invalid, nts_le_q, send_ok, rtx, base_up, map_set;
  logic [CW-1:0] clamp, nts_after;
  logic [CW:0]   clamp_inc;
  logic [SW-1:0] win_end;

  always_comb begin
    q_room     = queued_r < LAST_Q;
    rx_invalid = {1'b0, pseq_r} >= (PW + 1)'(SEQ_SPACE);
    clamp      = (XW'(pack_r) > XW'(queued_r)) ? queued_r : CW'(pack_r);
    clamp_inc  = {1'b0, clamp} + (CW + 1)'(1);
    base_up    = {1'b0, base_r} < clamp_inc;
    nts_le_q   = nts_r <= queued_r;
    win_end    = SW'(base_r) + SW'(ws_r);
    send_ok    = nts_le_q && (SW'(nts_r) < win_end);
    nts_after  = send_ok ? nts_r + CW'(1) : nts_r;
    rtx        = (elapsed_r >= to_r) && (base_r < nts_after);
    map_set    = cmd.exec && (func_r == swtc_pkg::FUNC_RECV) && !rx_invalid && (pseq_r != '0);
  end

  // Map write port: clearing pass or marking a received packet
  assign ram_we    = cmd.clear_step || map_set;
  assign ram_waddr = cmd.clear_step ? clr_r : AW'(pseq_r - PW'(1));
  assign ram_wdata = cmd.clear_step ? 1'b0 : 1'b1;

  swtc_ram #(
    .WIDTH (1),
    .DEPTH (SEQ_SPACE)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.scan_rd),
    .raddr (delivered_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Status to controller
  always_comb begin
    status.clear_last = (clr_r == LAST_A);
    status.func       = func_r;
    status.rx_invalid = rx_invalid;
    status.scan_more  = delivered_r < SPACE_C;
    status.map_bit    = ram_rdata[0];
    status.slot_any   = slot0_v_r || slot1_v_r;
    status.slot_two   = slot0_v_r && slot1_v_r;
    status.out_free   = !out_valid_r || out_tready;
  end

  assign cfg_ready = 1'b1;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= swtc_pkg::WINDOW_RESET;
      to_r        <= swtc_pkg::TIMEOUT_RESET;
      elapsed_r   <= '0;
      delivered_r <= '0;
      queued_r    <= '0;
      nts_r       <= CW'(1);
      base_r      <= CW'(1);
      ackp_r      <= 1'b0;
      clr_r       <= '0;
      slot0_v_r   <= 1'b0;
      slot1_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == swtc_pkg::REG_WINDOW_SIZE) begin
          ws_r <= cfg_data[swtc_pkg::WINDOW_W-1:0];
        end else begin
          to_r <= cfg_data;
        end
      end

      if (cmd.clear_step) begin
        clr_r <= clr_r + AW'(1);
      end

      if (cmd.exec) begin
        unique case (func_r)
          swtc_pkg::FUNC_QUEUE: begin
            if (q_room) begin
              queued_r <= queued_r + CW'(1);
            end
            slot0_v_r <= 1'b1;
            slot1_v_r <= 1'b0;
          end
          swtc_pkg::FUNC_RECV: begin
            // new cumulative ack moves the base and restarts the timer
            if (!rx_invalid && base_up) begin
              base_r    <= CW'(clamp_inc);
              elapsed_r <= '0;
            end
            slot0_v_r <= rx_invalid;
            slot1_v_r <= 1'b0;
          end
          swtc_pkg::FUNC_POLL: begin
            if (send_ok) begin
              nts_r <= nts_after;
            end else if (ackp_r) begin
              ackp_r <= 1'b0;
            end
            if (rtx) begin
              elapsed_r <= '0;
            end
            slot0_v_r <= send_ok || ackp_r;
            slot1_v_r <= rtx;
          end
          swtc_pkg::FUNC_TICK: begin
            if (elapsed_r != '1) begin
              elapsed_r <= elapsed_r + swtc_pkg::TIMER_W'(1);
            end
            slot0_v_r <= 1'b0;
            slot1_v_r <= 1'b0;
          end
          default: ;
        endcase
      end

      if (cmd.scan_adv) begin
        delivered_r <= delivered_r + CW'(1);
      end

      // nothing waiting to carry the ack: owe a pure ack
      if (cmd.rx_finish) begin
        if (!nts_le_q && (pseq_r != '0)) begin
          ackp_r <= 1'b1;
        end
        slot0_v_r <= 1'b1;
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        if (slot0_v_r) begin
          slot0_v_r <= 1'b0;
        end else begin
          slot1_v_r <= 1'b0;
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= swtc_pkg::func_t'(in_tuser);
      pseq_r <= in_tdata[PW-1:0];
      pack_r <= in_tdata[2*PW-1:PW];
    end

    if (cmd.exec) begin
      unique case (func_r)
        swtc_pkg::FUNC_QUEUE: begin
          slot0_kind_r <= q_room ? swtc_pkg::KIND_QUEUED : swtc_pkg::KIND_FULL;
          slot0_seq_r  <= q_room ? queued_r + CW'(1) : '0;
        end
        swtc_pkg::FUNC_RECV: begin
          slot0_kind_r <= swtc_pkg::KIND_INVALID;
          slot0_seq_r  <= '0;
          first_r      <= delivered_r + CW'(1);
          run_r        <= '0;
        end
        swtc_pkg::FUNC_POLL: begin
          slot0_kind_r <= send_ok ? swtc_pkg::KIND_SEND : swtc_pkg::KIND_PURE_ACK;
          slot0_seq_r  <= send_ok ? nts_r : '0;
          slot1_kind_r <= swtc_pkg::KIND_RETX;
          slot1_seq_r  <= base_r;
        end
        swtc_pkg::FUNC_TICK: ;
        default: ;
      endcase
    end

    if (cmd.scan_adv) begin
      run_r <= run_r + CW'(1);
    end

    if (cmd.rx_finish) begin
      slot0_kind_r <= swtc_pkg::KIND_DELIVERED;
      slot0_seq_r  <= (run_r != '0) ? first_r : '0;
    end

    if (cmd.emit) begin
      out_kind_r <= slot0_v_r ? slot0_kind_r : slot1_kind_r;
      out_seq_r  <= FW'(slot0_v_r ? slot0_seq_r : slot1_seq_r);
      out_ack_r  <= FW'(delivered_r);
      out_run_r  <= (slot0_v_r && (slot0_kind_r == swtc_pkg::KIND_DELIVERED)) ?
                    FW'(run_r) : '0;
      out_last_r <= !(slot0_v_r && slot1_v_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(swtc_pkg::OUT_TDATA_W - 3 * FW)'(0), out_run_r, out_ack_r, out_seq_r};

endmodule

[sv/sliding_window_transport_control.sv]
// Sliding-window sequence control for one reliable transport endpoint.
// After reset the received map is cleared one entry at a time, during which
// no request is taken (register writes are). Requests are then handled one at
// a time: a tick is executed and ends, a queue or a poll is executed and its
// result emitted (poll may give two results, the second after the first), and
// a valid receive also scans the map for the packets it delivers in order, up
// to the end of the map; the scan reads one map bit per read and check
// through a RAM with registered read. Results wait in an output register, so a
// new request may be taken while one is unread; a result that finds that
// register still full waits there for out_tready.
// Depends on swtc_pkg, swtc_ctrl, swtc_dp and swtc_ram.
`include "sliding_window_transport_control_assert.svh"

module sliding_window_transport_control #(
  parameter int SEQ_SPACE = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swtc_pkg::IN_TDATA_W-1:0]   in_tdata,   // [15:0] peer_seq, [31:16] peer_ack
  input  logic [swtc_pkg::FUNC_W-1:0]       in_tuser,   // [1:0] func
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swtc_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [10:0] seq_num, [21:11] ack_num,
                                                        // [32:22] run_count, [39:33] zero
  output logic [swtc_pkg::KIND_W-1:0]       out_tuser,  // [2:0] kind
  output logic                              out_tlast,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swtc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swtc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  swtc_pkg::cmd_t    cmd;
  swtc_pkg::status_t status;

  swtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swtc_dp #(
    .SEQ_SPACE (SEQ_SPACE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Checks
  `SWTC_ASSERT_IMP(a_no_request_in_clear, clk, rst_n, cmd.clear_step, !in_tready, "request taken during map clear")
  `SWTC_ASSERT_NXT(a_one_request_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "second request taken while busy")
  `SWTC_ASSERT_IMP(a_push_only_when_free, clk, rst_n, cmd.emit, status.out_free, "result pushed over an unread result")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking bench for sliding_window_transport_control: directed table,
// then random traffic over several register settings.
// Depends on swtc_pkg and the controller RTL only.
module testbench;

  localparam int SEQ_SPACE     = 1024;
  localparam int MAP_AW        = $clog2(SEQ_SPACE);
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 171;

  // One result as it leaves the block
  typedef struct packed {
    swtc_pkg::kind_t              kind;
    logic [swtc_pkg::FIELD_W-1:0] seq_num;
    logic [swtc_pkg::FIELD_W-1:0] ack_num;
    logic [swtc_pkg::FIELD_W-1:0] run_count;
    logic                         last;
  } result_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_t;

  // Directed row; for ROW_CFG, peer_seq carries the register index and peer_ack the value
  typedef struct packed {
    row_op_t         op;
    swtc_pkg::func_t func;
    logic [15:0]     peer_seq;
    logic [15:0]     peer_ack;
    logic            fixed;
    result_t         want;
  } row_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [swtc_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic [swtc_pkg::FUNC_W-1:0]      in_tuser = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [swtc_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [swtc_pkg::KIND_W-1:0]      out_tuser;
  logic                             out_tlast;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [swtc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [swtc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Predicted endpoint state
  logic                             rx_map [SEQ_SPACE];
  logic [swtc_pkg::FIELD_W-1:0]     dlv_count;
  logic [swtc_pkg::FIELD_W-1:0]     q_count;
  logic [swtc_pkg::FIELD_W-1:0]     nxt_send;
  logic [swtc_pkg::FIELD_W-1:0]     win_base;
  logic                             ack_owed;
  logic [swtc_pkg::TIMER_W-1:0]     tick_count;
  logic [swtc_pkg::WINDOW_W-1:0]    cfg_window;
  logic [swtc_pkg::TIMER_W-1:0]     cfg_timeout;

  result_t                step_results [$];
  result_t                expected_results [$];
  result_t                got;
  result_t                want;
  row_t                   directed_plan [26];
  logic [15:0]            window_plan [6] = '{16'd4, 16'd1, 16'd1024, 16'hFC08, 16'd0, 16'd300};
  logic [15:0]            timeout_plan [6] = '{16'd20, 16'd5, 16'd1, 16'd60, 16'd0, 16'd3};
  int                     mismatches = 0;
  int                     result_index = 0;
  int                     cycles = 0;
  int                     sink_hold = 0;
  logic                   sender_calm = 1'b0;

  sliding_window_transport_control #(
    .SEQ_SPACE(SEQ_SPACE)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(99));
    if (r < 55) return 0;
    if (r < 85) return int'($urandom_range(3, 1));
    if (r < 97) return int'($urandom_range(12, 4));
    return int'($urandom_range(60, 20));
  endfunction

  function automatic void add_result(swtc_pkg::kind_t k, int seq, int run);
    result_t r;
    r.kind      = k;
    r.seq_num   = seq[swtc_pkg::FIELD_W-1:0];
    r.ack_num   = dlv_count;
    r.run_count = run[swtc_pkg::FIELD_W-1:0];
    r.last      = 1'b0;
    step_results.push_back(r);
  endfunction

  // Endpoint update for one accepted request; results land in step_results
  task automatic model_request(input swtc_pkg::func_t f, input logic [15:0] pseq,
                               input logic [15:0] pack);
    int      ack;
    int      first;
    int      run;
    result_t r;
    step_results.delete();
    unique case (f)
      swtc_pkg::FUNC_QUEUE: begin
        if (q_count < SEQ_SPACE - 1) begin
          q_count = q_count + 1'b1;
          add_result(swtc_pkg::KIND_QUEUED, int'(q_count), 0);
        end else begin
          add_result(swtc_pkg::KIND_FULL, 0, 0);
        end
      end
      swtc_pkg::FUNC_RECV: begin
        if (pseq >= SEQ_SPACE) begin
          add_result(swtc_pkg::KIND_INVALID, 0, 0);
        end else begin
          first = int'(dlv_count) + 1;
          run   = 0;
          if (pseq != 0) rx_map[MAP_AW'(pseq - 16'd1)] = 1'b1;
          // peer cannot ack more than has been queued
          ack = (pack > q_count) ? int'(q_count) : int'(pack);
          if (int'(win_base) < ack + 1) begin
            win_base   = swtc_pkg::FIELD_W'(ack + 1);
            tick_count = '0;
          end
          while (dlv_count < SEQ_SPACE && rx_map[dlv_count[MAP_AW-1:0]]) begin
            dlv_count = dlv_count + 1'b1;
            run++;
          end
          if (!(nxt_send <= q_count) && pseq != 0) ack_owed = 1'b1;
          add_result(swtc_pkg::KIND_DELIVERED, (run != 0) ? first : 0, run);
        end
      end
      swtc_pkg::FUNC_POLL: begin
        if (nxt_send <= q_count && int'(nxt_send) < int'(win_base) + int'(cfg_window)) begin
          add_result(swtc_pkg::KIND_SEND, int'(nxt_send), 0);
          nxt_send = nxt_send + 1'b1;
        end else if (ack_owed) begin
          ack_owed = 1'b0;
          add_result(swtc_pkg::KIND_PURE_ACK, 0, 0);
        end
        if (tick_count >= cfg_timeout && win_base < nxt_send) begin
          add_result(swtc_pkg::KIND_RETX, int'(win_base), 0);
          tick_count = '0;
        end
      end
      default: begin
        if (tick_count != 16'hFFFF) tick_count = tick_count + 1'b1;
      end
    endcase
    if (step_results.size() != 0) begin
      r      = step_results.pop_back();
      r.last = 1'b1;
      step_results.push_back(r);
    end
  endtask

  // Present one request, wait for its acceptance, predict, then idle a while
  task automatic send_request(input swtc_pkg::func_t f, input logic [15:0] pseq,
                              input logic [15:0] pack,
                              input logic fixed, input result_t fixed_res);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {pack, pseq};
    do @(posedge clk); while (in_tready !== 1'b1);
    model_request(f, pseq, pack);
    if (fixed) begin
      expected_results.push_back(fixed_res);
    end else begin
      foreach (step_results[i]) expected_results.push_back(step_results[i]);
    end
    gap = sender_calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every predicted result is out and the block has gone quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, then a wait with the write channel quiet
  task automatic write_register(input logic [swtc_pkg::CFG_IDX_W-1:0] idx,
                                input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == swtc_pkg::REG_WINDOW_SIZE) cfg_window = val[swtc_pkg::WINDOW_W-1:0];
    else cfg_timeout = val;
    @(posedge clk);
  endtask

  // Mostly well-formed traffic around the current window, some noise
  task automatic random_request();
    int          r;
    int          s;
    logic [15:0] pseq;
    logic [15:0] pack;
    r    = int'($urandom_range(99));
    pseq = 16'($urandom);
    pack = 16'($urandom);
    if (r < 30) begin
      send_request(swtc_pkg::FUNC_QUEUE, pseq, pack, 1'b0, '0);
    end else if (r < 55) begin
      send_request(swtc_pkg::FUNC_POLL, pseq, pack, 1'b0, '0);
    end else if (r < 70) begin
      send_request(swtc_pkg::FUNC_TICK, pseq, pack, 1'b0, '0);
    end else begin
      r = int'($urandom_range(99));
      if (r < 80) begin
        // ack somewhere between the window base and what has been sent
        pack = 16'($urandom_range(int'(win_base) - 1, int'(nxt_send) - 1));
        s    = int'(dlv_count) + 1 + int'($urandom_range(4, 0));
        pseq = (r < 70) ? 16'((s > SEQ_SPACE - 1) ? SEQ_SPACE - 1 : s) : 16'd0;
      end else if (r < 90) begin
        pseq = 16'($urandom_range(SEQ_SPACE - 1, 1));
        pack = 16'($urandom_range(int'(q_count) + 5, 0));
      end
      send_request(swtc_pkg::FUNC_RECV, pseq, pack, 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH: %s", msg);
  endtask

  // Result sink with random back-pressure, quiet in one quarter of the time
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold  <= sink_hold - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (cycles[9:8] != 2'd0 && $urandom_range(99) < 30) sink_hold <= pick_gap();
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got.kind      = swtc_pkg::kind_t'(out_tuser);
      got.seq_num   = out_tdata[10:0];
      got.ack_num   = out_tdata[21:11];
      got.run_count = out_tdata[32:22];
      got.last      = out_tlast;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d unexpected: kind %0d seq %0d", result_index,
                                  out_tuser, got.seq_num));
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.kind || got.seq_num !== want.seq_num ||
            got.ack_num !== want.ack_num || got.run_count !== want.run_count ||
            got.last !== want.last || out_tdata[39:33] !== 7'd0)
          report_mismatch($sformatf(
            "result %0d kind %0d/%0d seq %0d/%0d ack %0d/%0d run %0d/%0d last %0b/%0b pad %0h",
            result_index, out_tuser, want.kind, got.seq_num, want.seq_num, got.ack_num,
            want.ack_num, got.run_count, want.run_count, got.last, want.last,
            out_tdata[39:33]));
      end
      result_index++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sliding_window_transport_control test failed");
      $finish;
    end
  end

  initial begin
    foreach (rx_map[i]) rx_map[i] = 1'b0;
    dlv_count   = '0;
    q_count     = '0;
    nxt_send    = 11'd1;
    win_base    = 11'd1;
    ack_owed    = 1'b0;
    tick_count  = '0;
    cfg_window  = swtc_pkg::WINDOW_RESET;
    cfg_timeout = swtc_pkg::TIMEOUT_RESET;

    // Directed: reset values first, then zero registers, window edges and the timer
    directed_plan = '{
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd1024, 16'd0,    1'b1,
        '{swtc_pkg::KIND_INVALID, 11'd0, 11'd0, 11'd0, 1'b1}},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'hFFFF, 16'hFFFF, 1'b1,
        '{swtc_pkg::KIND_INVALID, 11'd0, 11'd0, 11'd0, 1'b1}},
      '{ROW_REQ, swtc_pkg::FUNC_QUEUE, 16'd0,    16'd0,    1'b1,
        '{swtc_pkg::KIND_QUEUED,  11'd1, 11'd0, 11'd0, 1'b1}},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b1,
        '{swtc_pkg::KIND_SEND,    11'd1, 11'd0, 11'd0, 1'b1}},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{ROW_CFG, swtc_pkg::FUNC_QUEUE, 16'(swtc_pkg::REG_TIMEOUT),     16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_CFG, swtc_pkg::FUNC_QUEUE, 16'(swtc_pkg::REG_WINDOW_SIZE), 16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_QUEUE, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd1,    16'd1,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd3,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd2,    16'hFFFF, 1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd5,    16'd0,    1'b0, '0},
      '{ROW_CFG, swtc_pkg::FUNC_QUEUE, 16'(swtc_pkg::REG_WINDOW_SIZE), 16'd1024, 1'b0, '0},
      '{ROW_CFG, swtc_pkg::FUNC_QUEUE, 16'(swtc_pkg::REG_TIMEOUT),     16'd2,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_QUEUE, 16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_TICK,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_TICK,  16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_RECV,  16'd1023, 16'd3,    1'b0, '0},
      '{ROW_REQ, swtc_pkg::FUNC_POLL,  16'd0,    16'd0,    1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == ROW_CFG) begin
        drain_results();
        write_register(directed_plan[i].peer_seq[swtc_pkg::CFG_IDX_W-1:0],
                       directed_plan[i].peer_ack);
      end else begin
        send_request(directed_plan[i].func, directed_plan[i].peer_seq, directed_plan[i].peer_ack,
                     directed_plan[i].fixed, directed_plan[i].want);
      end
    end

    // Random traffic under several register settings
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_register(swtc_pkg::REG_WINDOW_SIZE, window_plan[p]);
      write_register(swtc_pkg::REG_TIMEOUT, timeout_plan[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sender_calm = (n < 40);
        random_request();
        if ($urandom_range(149) == 0) drain_results();
      end
    end
    sender_calm = 1'b0;

    drain_results();
    if (mismatches == 0) begin
      $display("sliding_window_transport_control test passed");
    end else begin
      $display("sliding_window_transport_control test failed");
    end
    $finish;
  end

endmodule
